/* design/assert_macros.svh */
// Assertion macros shared by the CSV decoder modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// ante implies cons in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/csvd_pkg.sv */
// Shared types and constants for the CSV field decoder.
// No dependencies; used by csvd_step, csvd_rbuf and csv_field_decoder.
package csvd_pkg;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_END   = 8'h00;

	localparam int RBUF_DEPTH = 4;
	localparam int RBUF_AW    = 2;
	localparam int RBUF_CW    = 3;

	typedef enum logic [4:0] {
		M_START  = 5'b00001,
		M_PLAIN  = 5'b00010,
		M_QUOTED = 5'b00100,
		M_QSEEN  = 5'b01000,
		M_DONE   = 5'b10000
	} mode_t;

	typedef enum logic [2:0] {
		K_DATA = 3'd0,
		K_FEND = 3'd1,
		K_LEND = 3'd2,
		K_END  = 3'd3,
		K_BAD  = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] line;
		logic        last;
	} res_t;

	// decode of one byte: up to two results plus the state update
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
		mode_t      mode_nx;
		logic       bump;
	} step_t;

endpackage

/* design/csvd_step.sv */
// Byte decoder: parse mode and one byte in, results and next mode out.
// Purely combinational; depends on csvd_pkg.
module csvd_step (
	input  csvd_pkg::mode_t mode,
	input  logic [7:0]      char_cur,
	input  logic [15:0]     line,
	output csvd_pkg::step_t step
);

	always_comb begin
		step.count   = 2'd0;
		step.bump    = 1'b0;
		step.mode_nx = mode;
		step.r0.kind = csvd_pkg::K_DATA;
		step.r0.data = 8'd0;
		step.r0.line = line;
		step.r0.last = 1'b0;
		step.r1.kind = csvd_pkg::K_DATA;
		step.r1.data = 8'd0;
		step.r1.line = line;
		step.r1.last = 1'b1;

		case (mode)
			csvd_pkg::M_START: begin
				if (char_cur == csvd_pkg::CH_END) begin
					step.count   = 2'd1;
					step.r0.kind = csvd_pkg::K_END;
					step.mode_nx = csvd_pkg::M_DONE;
				end else if (char_cur == csvd_pkg::CH_QUOTE) begin
					step.mode_nx = csvd_pkg::M_QUOTED;
				end else if (char_cur == csvd_pkg::CH_CR || char_cur == csvd_pkg::CH_LF) begin
					// empty field before a line end is dropped
					step.count   = 2'd1;
					step.r0.kind = csvd_pkg::K_LEND;
					step.bump    = 1'b1;
				end else if (char_cur == csvd_pkg::CH_COMMA) begin
					step.count   = 2'd1;
					step.r0.kind = csvd_pkg::K_FEND;
				end else begin
					step.count   = 2'd1;
					step.r0.data = char_cur;
					step.mode_nx = csvd_pkg::M_PLAIN;
				end
			end
			csvd_pkg::M_PLAIN: begin
				if (char_cur == csvd_pkg::CH_COMMA) begin
					step.count   = 2'd1;
					step.r0.kind = csvd_pkg::K_FEND;
					step.mode_nx = csvd_pkg::M_START;
				end else if (char_cur == csvd_pkg::CH_LF) begin
					step.count   = 2'd2;
					step.r0.kind = csvd_pkg::K_FEND;
					step.r1.kind = csvd_pkg::K_LEND;
					step.bump    = 1'b1;
					step.mode_nx = csvd_pkg::M_START;
				end else if (char_cur == csvd_pkg::CH_END) begin
					step.count   = 2'd2;
					step.r0.kind = csvd_pkg::K_FEND;
					step.r1.kind = csvd_pkg::K_END;
					step.mode_nx = csvd_pkg::M_DONE;
				end else begin
					// CR and quote are plain data here
					step.count   = 2'd1;
					step.r0.data = char_cur;
				end
			end
			csvd_pkg::M_QUOTED: begin
				if (char_cur == csvd_pkg::CH_END) begin
					step.count   = 2'd1;
					step.r0.kind = csvd_pkg::K_BAD;
					step.mode_nx = csvd_pkg::M_DONE;
				end else if (char_cur == csvd_pkg::CH_QUOTE) begin
					step.mode_nx = csvd_pkg::M_QSEEN;
				end else begin
					step.count   = 2'd1;
					step.r0.data = char_cur;
				end
			end
			csvd_pkg::M_QSEEN: begin
				if (char_cur == csvd_pkg::CH_QUOTE) begin
					// doubled quote
					step.count   = 2'd1;
					step.r0.data = csvd_pkg::CH_QUOTE;
					step.mode_nx = csvd_pkg::M_QUOTED;
				end else if (char_cur == csvd_pkg::CH_COMMA) begin
					step.count   = 2'd1;
					step.r0.kind = csvd_pkg::K_FEND;
					step.mode_nx = csvd_pkg::M_START;
				end else if (char_cur == csvd_pkg::CH_LF || char_cur == csvd_pkg::CH_CR) begin
					step.count   = 2'd2;
					step.r0.kind = csvd_pkg::K_FEND;
					step.r1.kind = csvd_pkg::K_LEND;
					step.bump    = 1'b1;
					step.mode_nx = csvd_pkg::M_START;
				end else if (char_cur == csvd_pkg::CH_END) begin
					step.count   = 2'd2;
					step.r0.kind = csvd_pkg::K_FEND;
					step.r1.kind = csvd_pkg::K_END;
					step.mode_nx = csvd_pkg::M_DONE;
				end else begin
					step.count   = 2'd1;
					step.r0.kind = csvd_pkg::K_BAD;
					step.mode_nx = csvd_pkg::M_DONE;
				end
			end
			default: begin
				step.mode_nx = csvd_pkg::M_DONE;
			end
		endcase

		step.r0.last = (step.count == 2'd1);
	end

endmodule

/* design/csvd_rbuf.sv */
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on csvd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csvd_rbuf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    push,
	input  csvd_pkg::res_t                push_r0,
	input  csvd_pkg::res_t                push_r1,
	output logic [csvd_pkg::RBUF_CW-1:0]  space,
	output logic                          res_valid,
	input  logic                          res_ready,
	output csvd_pkg::res_t                res
);

	csvd_pkg::res_t                mem_q [csvd_pkg::RBUF_DEPTH];
	logic [csvd_pkg::RBUF_AW-1:0]  wptr_q;
	logic [csvd_pkg::RBUF_AW-1:0]  rptr_q;
	logic [csvd_pkg::RBUF_CW-1:0]  count_q;
	logic [csvd_pkg::RBUF_AW-1:0]  wptr_p1;
	logic                          pop;

	assign pop       = res_valid && res_ready;
	assign res_valid = (count_q != '0);
	assign res       = mem_q[rptr_q];
	assign wptr_p1   = wptr_q + csvd_pkg::RBUF_AW'(1);
	// free entries once this cycle's pop has gone
	assign space     = csvd_pkg::RBUF_CW'(csvd_pkg::RBUF_DEPTH) - count_q
		+ csvd_pkg::RBUF_CW'(pop);

	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			mem_q[wptr_q] <= push_r0;
		end
		if (push == 2'd2) begin
			mem_q[wptr_p1] <= push_r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + csvd_pkg::RBUF_AW'(push);
			rptr_q  <= rptr_q + csvd_pkg::RBUF_AW'(pop);
			count_q <= count_q + csvd_pkg::RBUF_CW'(push) - csvd_pkg::RBUF_CW'(pop);
		end
	end

	`ASSERT_ALWAYS(a_count_max, count_q <= csvd_pkg::RBUF_CW'(csvd_pkg::RBUF_DEPTH))
	`ASSERT_IMPL(a_push_fits, push != 2'd0, csvd_pkg::RBUF_CW'(push) <= space)
	`ASSERT_NEXT(a_drain, pop && count_q == csvd_pkg::RBUF_CW'(1) && push == 2'd0, !res_valid)

endmodule

/* design/csv_field_decoder.sv */
// CSV field decoder top level: input register, byte decoder, result queue.
// The first result of a byte is offered once the byte has passed the input register
// and been written into the result queue.
// Throughput: one byte per cycle while the queue has room for its results; a byte yielding
// two results (field end plus line or data end) sends both through the single result port.
// Reset (arst_n low): parse mode to field start, line count to one, queue empty.
`include "assert_macros.svh"

module csv_field_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_in,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  kind,
	output logic [7:0]  data_byte,
	output logic [15:0] line_number,
	output logic        last
);

	logic                          valid_s1;
	logic [7:0]                    char_s1;
	csvd_pkg::mode_t               mode_q;
	logic [15:0]                   line_q;
	csvd_pkg::step_t               step;
	logic [csvd_pkg::RBUF_CW-1:0]  space;
	logic                          advance;
	logic [1:0]                    push;
	csvd_pkg::res_t                res;

	csvd_step u_step (
		.mode     (mode_q),
		.char_cur (char_s1),
		.line     (line_q),
		.step     (step)
	);

	// byte in s1 retires only when all its results fit in the queue
	assign advance    = valid_s1 && (csvd_pkg::RBUF_CW'(step.count) <= space);
	assign push       = advance ? step.count : 2'd0;
	assign char_ready = !valid_s1 || advance;

	csvd_rbuf u_rbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_r0   (step.r0),
		.push_r1   (step.r1),
		.space     (space),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign kind        = res.kind;
	assign data_byte   = res.data;
	assign line_number = res.line;
	assign last        = res.last;

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			char_s1 <= char_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= csvd_pkg::M_START;
			line_q   <= 16'd1;
		end else begin
			if (char_ready) begin
				valid_s1 <= char_valid;
			end
			if (advance) begin
				mode_q <= step.mode_nx;
				if (step.bump && line_q != 16'hFFFF) begin
					line_q <= line_q + 16'd1;
				end
			end
		end
	end

	`ASSERT_ALWAYS(a_line_nonzero, line_q != 16'd0)
	`ASSERT_NEXT(a_line_sat, line_q == 16'hFFFF, line_q == 16'hFFFF)
	`ASSERT_IMPL(a_done_silent, valid_s1 && mode_q == csvd_pkg::M_DONE, step.count == 2'd0)

endmodule
